// ===== hw/rtl/pcts_pkg.sv =====
// Package for the prefix code tree store: field widths, status and op codes,
// controller state encoding and the command/status bundles.
// No dependencies.
package pcts_pkg;

	// Default node table depth
	localparam int PCTS_TREE_NODES = 512;

	// Longest code walked; longer lengths are clamped to this
	localparam int MAX_CODE_LEN = 16;

	// Fixed field widths
	localparam int CODE_W = 16;
	localparam int LEN_W  = 5;
	localparam int PAY_W  = 32;
	localparam int ST_W   = 2;

	// Operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// Result status codes
	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

	// Controller states, one-hot
	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WALK = 3'b010,
		S_FIN  = 3'b100
	} ctrl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;    // capture an input beat, start at the root
		logic step;    // walk one code bit
		logic finish;  // store/fetch at the final node, load the result register
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic len_zero;   // incoming code addresses the root
		logic advance;    // this step moves to a child (existing or new)
		logic last_step;  // one code bit left
	} dp_stat_t;

endpackage

// ===== hw/rtl/pcts_ctrl.sv =====
// Controller for the prefix code tree store: sequences load, walk and finish.
// Depends on pcts_pkg.
module pcts_ctrl import pcts_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        fin_go;

	// Result register free, or being drained this cycle
	assign fin_go = (state_q == S_FIN) && (!out_valid_q || out_ready);

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.step   = 1'b0;
		cmd.finish = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = stat.len_zero ? S_FIN : S_WALK;
				end
			end
			S_WALK: begin
				cmd.step = 1'b1;
				if (!stat.advance || stat.last_step) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (fin_go) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and result-valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== hw/rtl/pcts_datapath.sv =====
// Datapath for the prefix code tree store: node table memories, root node
// registers, walk registers, allocator and result register.
// Depends on pcts_pkg.
module pcts_datapath import pcts_pkg::*; #(
	parameter int TREE_NODES = PCTS_TREE_NODES
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dp_cmd_t                 cmd,
	output dp_stat_t                stat,
	input  logic                    op,
	input  logic [CODE_W-1:0]       code_bits,
	input  logic [LEN_W-1:0]        code_length,
	input  logic signed [PAY_W-1:0] value,
	output logic signed [PAY_W-1:0] payload_out,
	output logic [ST_W-1:0]         status
);

	localparam int IDX_W = $clog2(TREE_NODES);
	localparam logic [IDX_W:0] NODES_EXT = (IDX_W+1)'(TREE_NODES);

	typedef struct packed {
		logic             filled;
		logic [IDX_W-1:0] left;
		logic [IDX_W-1:0] right;
	} node_t;

	// Walk registers
	logic              op_q;
	logic [CODE_W-1:0] bits_q;
	logic [LEN_W-1:0]  cnt_q;
	logic [PAY_W-1:0]  val_q;
	logic [IDX_W-1:0]  cur_q;
	logic              fresh_q;     // current node was allocated in this walk
	logic [ST_W-1:0]   code_q;
	logic [IDX_W-1:0]  last_alloc_q;

	// Root node lives in registers so reset clears it at once
	node_t             root_q;
	logic [PAY_W-1:0]  root_pay_q;

	// Node table; entries above last_alloc_q are never read
	node_t             ent_mem [TREE_NODES];
	logic [PAY_W-1:0]  pay_mem [TREE_NODES];
	node_t             ent_rd_q;
	logic [PAY_W-1:0]  pay_rd_q;

	// Result register
	logic [PAY_W-1:0]  payload_out_q;
	logic [ST_W-1:0]   status_q;

	logic [LEN_W-1:0]  len_clamp;
	logic [LEN_W-1:0]  bit_pos;
	logic [CODE_W-1:0] bits_shr;
	logic              cur_bit;
	node_t             cur_ent;
	node_t             upd_ent;
	node_t             ent_wdata;
	logic [IDX_W-1:0]  child_raw;
	logic [IDX_W-1:0]  child;
	logic              child_hit;
	logic [IDX_W:0]    new_idx_ext;
	logic [IDX_W-1:0]  new_idx;
	logic              alloc_full;
	logic              step_alloc;
	logic              fin_ins_ok;
	logic              fin_full_fresh;
	logic              ent_we;
	logic              lookup_ok;
	logic [IDX_W-1:0]  rd_addr;

	// Length clamp on the incoming beat
	assign len_clamp = (code_length > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN)
		: code_length;

	// Current code bit, most significant valid bit first
	assign bit_pos  = cnt_q - 1'b1;
	assign bits_shr = bits_q >> bit_pos;
	assign cur_bit  = bits_shr[0];

	// Entry of the current node: root regs, a fresh (empty) node or memory
	always_comb begin
		if (cur_q == '0) begin
			cur_ent = root_q;
		end else if (fresh_q) begin
			cur_ent = '0;
		end else begin
			cur_ent = ent_rd_q;
		end
	end

	// Child lookup; an out-of-range index counts as no child
	assign child_raw = cur_bit ? cur_ent.right : cur_ent.left;
	assign child     = ({1'b0, child_raw} >= NODES_EXT) ? '0 : child_raw;
	assign child_hit = (child != '0);

	// Allocator
	assign new_idx_ext = {1'b0, last_alloc_q} + 1'b1;
	assign alloc_full  = (new_idx_ext >= NODES_EXT);
	assign new_idx     = new_idx_ext[IDX_W-1:0];

	// Current entry with the walked slot pointing at the new node
	always_comb begin
		upd_ent = cur_ent;
		if (cur_bit) begin
			upd_ent.right = new_idx;
		end else begin
			upd_ent.left = new_idx;
		end
	end

	// Node table writes: link on allocation, mark at finish, and initialize
	// a freshly made node left behind when the table fills
	assign step_alloc     = cmd.step && !child_hit && (op_q == OP_INSERT) && !alloc_full;
	assign fin_ins_ok     = cmd.finish && (op_q == OP_INSERT) && (code_q == ST_OK);
	assign fin_full_fresh = cmd.finish && (code_q == ST_FULL) && fresh_q;
	assign ent_we         = step_alloc || fin_ins_ok || fin_full_fresh;

	always_comb begin
		if (step_alloc) begin
			ent_wdata = upd_ent;
		end else if (fin_ins_ok) begin
			ent_wdata        = cur_ent;
			ent_wdata.filled = 1'b1;
		end else begin
			ent_wdata = '0;
		end
	end

	// Read ahead at the child being moved to
	assign rd_addr = (cmd.step && child_hit) ? child : cur_q;

	// Node table memories
	always_ff @(posedge clk) begin
		if (ent_we && (cur_q != '0)) begin
			ent_mem[cur_q] <= ent_wdata;
		end
		if (fin_ins_ok && (cur_q != '0)) begin
			pay_mem[cur_q] <= val_q;
		end
		ent_rd_q <= ent_mem[rd_addr];
		pay_rd_q <= pay_mem[rd_addr];
	end

	// Root node and allocation counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q       <= '0;
			root_pay_q   <= '0;
			last_alloc_q <= '0;
		end else begin
			if (ent_we && (cur_q == '0)) begin
				root_q <= ent_wdata;
			end
			if (fin_ins_ok && (cur_q == '0)) begin
				root_pay_q <= val_q;
			end
			if (step_alloc) begin
				last_alloc_q <= new_idx;
			end
		end
	end

	// Walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			cur_q   <= '0;
			fresh_q <= 1'b0;
			code_q  <= ST_OK;
			op_q    <= OP_INSERT;
		end else if (cmd.load) begin
			op_q    <= op;
			cnt_q   <= len_clamp;
			cur_q   <= '0;
			fresh_q <= 1'b0;
			code_q  <= ST_OK;
		end else if (cmd.step) begin
			if (child_hit) begin
				cur_q   <= child;
				fresh_q <= 1'b0;
				cnt_q   <= cnt_q - 1'b1;
			end else if (op_q == OP_LOOKUP) begin
				code_q <= ST_NOT_FOUND;
			end else if (alloc_full) begin
				code_q <= ST_FULL;
			end else begin
				cur_q   <= new_idx;
				fresh_q <= 1'b1;
				cnt_q   <= cnt_q - 1'b1;
			end
		end
	end

	// Beat payload, held for the whole walk
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bits_q <= code_bits;
			val_q  <= value;
		end
	end

	// Result register
	assign lookup_ok = (op_q == OP_LOOKUP) && (code_q == ST_OK);

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (lookup_ok && cur_ent.filled) begin
				payload_out_q <= (cur_q == '0) ? root_pay_q : pay_rd_q;
			end else begin
				payload_out_q <= '0;
			end
			status_q <= (lookup_ok && !cur_ent.filled) ? ST_NOT_FOUND : code_q;
		end
	end

	assign payload_out = payload_out_q;
	assign status      = status_q;

	// Status to controller
	assign stat.len_zero  = (len_clamp == '0);
	assign stat.advance   = child_hit || ((op_q == OP_INSERT) && !alloc_full);
	assign stat.last_step = (cnt_q == LEN_W'(1));

endmodule

// ===== hw/rtl/prefix_code_tree_store_top.sv =====
// Top level of the prefix code tree store: controller plus datapath.
// Depends on pcts_pkg, pcts_ctrl and pcts_datapath.
//
// Holds a binary code tree in a TREE_NODES-entry node table. An insert walks
// the code (bit code_length-1 first, 0 left, 1 right), allocating missing
// nodes in order, and stores value at the final node; a lookup returns the
// payload or status not-found, and an insert that runs out of nodes returns
// table-full and keeps the nodes it made. One item is worked at a time: an
// accept state, a walk state that takes one code bit at a time (each bit needs
// one registered read of the node table memory) and a finish state, with
// code_length clamped to 16; a lookup miss or a full table ends the walk at
// the failing bit. The result sits in an output register, so the next beat
// can be accepted while it waits; a result still held there stalls the
// finish state of the next item. The root node is held in registers and nodes
// are initialized as they are allocated, so no clearing pass follows reset.
module prefix_code_tree_store_top import pcts_pkg::*; #(
	parameter int TREE_NODES = PCTS_TREE_NODES
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    op,
	input  logic [CODE_W-1:0]       code_bits,
	input  logic [LEN_W-1:0]        code_length,
	input  logic signed [PAY_W-1:0] value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [PAY_W-1:0] payload_out,
	output logic [ST_W-1:0]         status
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	pcts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pcts_datapath #(
		.TREE_NODES (TREE_NODES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.op          (op),
		.code_bits   (code_bits),
		.code_length (code_length),
		.value       (value),
		.payload_out (payload_out),
		.status      (status)
	);

endmodule

// ===== hw/rtl/pcts_checker.sv =====
// Port-level checker for the prefix code tree store, bound to the top level.
// Depends on pcts_pkg.
module pcts_checker import pcts_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [PAY_W-1:0] payload_out,
	input logic [ST_W-1:0]         status
);

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(payload_out) && $stable(status))
		else $error("result beat changed while stalled");

	// Only defined status codes leave the block
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK) || (status == ST_NOT_FOUND) || (status == ST_FULL))
		else $error("undefined status code");

	// Failed items carry a zero payload
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> payload_out == '0)
		else $error("nonzero payload on failed item");

	// One item at a time: no beat taken right after one was accepted
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after an accepted beat");

endmodule

bind prefix_code_tree_store_top pcts_checker u_chk (.*);
